[rtl/varint_zigzag_encoder_macros.svh]
// Assertion macros shared by the varint encoder RTL.
`ifndef VARINT_ZIGZAG_ENCODER_MACROS_SVH
`define VARINT_ZIGZAG_ENCODER_MACROS_SVH

// Checked on every rising clk_i edge, muted while rst_ni is low.
`define VZE_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vze assertion failed");

// Checked on every rising clk_i edge, also during reset.
`define VZE_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("vze assertion failed");

`endif

[rtl/vze_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vze_pkg
// Types and constants for the zigzag varint encoder.
// ---------------------------------------------------------------------------
package vze_pkg;

  localparam int unsigned GroupLimit = 8;
  localparam int unsigned CntW       = $clog2(GroupLimit + 1);

  typedef enum logic [2:0] {
    KIND_INT16  = 3'd0,
    KIND_UINT16 = 3'd1,
    KIND_INT32  = 3'd2,
    KIND_UINT32 = 3'd3,
    KIND_INT64  = 3'd4,
    KIND_UINT64 = 3'd5
  } kind_e;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  value_kind;
    logic        last_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       end_of_call;
    logic       bad_kind;
  } out_beat_t;

  // One classified item as queued between front and back.
  typedef struct packed {
    logic [63:0] mapped;
    logic        bad;
    logic        last_value;
  } job_t;

endpackage

[rtl/vze_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vze_front
// Decodes the kind and zigzag-maps the signed kinds within their width.
// ---------------------------------------------------------------------------
module vze_front (
  input  vze_pkg::in_beat_t beat_i,
  output vze_pkg::job_t     job_o
);
  import vze_pkg::*;

  logic s;

  always_comb begin
    job_o.last_value = beat_i.last_value;
    job_o.bad        = 1'b0;
    job_o.mapped     = '0;
    s                = 1'b0;
    case (beat_i.value_kind)
      KIND_INT16: begin
        s            = beat_i.value[15];
        job_o.mapped = {48'd0, beat_i.value[14:0] ^ {15{s}}, s};
      end
      KIND_UINT16: job_o.mapped = {48'd0, beat_i.value[15:0]};
      KIND_INT32: begin
        s            = beat_i.value[31];
        job_o.mapped = {32'd0, beat_i.value[30:0] ^ {31{s}}, s};
      end
      KIND_UINT32: job_o.mapped = {32'd0, beat_i.value[31:0]};
      KIND_INT64: begin
        s            = beat_i.value[63];
        job_o.mapped = {beat_i.value[62:0] ^ {63{s}}, s};
      end
      KIND_UINT64: job_o.mapped = beat_i.value;
      default:     job_o.bad    = 1'b1;
    endcase
  end

endmodule

[rtl/vze_fifo.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vze_fifo
// Small register queue of classified jobs between front and back.
// ---------------------------------------------------------------------------
`include "varint_zigzag_encoder_macros.svh"

module vze_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vze_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output vze_pkg::job_t data_o
);
  import vze_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW2 = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW2-1:0] count_q, count_d;

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    ptr_inc = (p == AddrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW2'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `VZE_ASSERT(a_no_overflow, full_o |-> !push_i || pop_i)
  `VZE_ASSERT(a_no_underflow, pop_i |-> valid_o)
  `VZE_ASSERT(a_count_bound, count_q <= CntW2'(Depth))

endmodule

[rtl/vze_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// vze_back
// Serializes a queued job to 7-bit groups, one byte per cycle unless stalled.
// ---------------------------------------------------------------------------
`include "varint_zigzag_encoder_macros.svh"

module vze_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  vze_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vze_pkg::out_beat_t out_o
);
  import vze_pkg::*;

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [63:0]     rest_q, rest_d;
  logic            lastv_q, lastv_d;
  logic            out_valid_q, out_valid_d;
  out_beat_t       out_q, out_d;

  logic            can_emit, emit;
  logic [63:0]     src;
  logic [CntW-1:0] src_cnt;
  logic            src_last_value, more, ninth, last;

  // Source is the job in flight, or the queue head when starting a new one.
  assign src            = busy_q ? rest_q  : job_i.mapped;
  assign src_cnt        = busy_q ? cnt_q   : '0;
  assign src_last_value = busy_q ? lastv_q : job_i.last_value;
  assign more           = |src[63:7];
  assign ninth          = (src_cnt == CntW'(GroupLimit));
  assign last           = ninth || !more;

  assign can_emit  = !out_valid_q || out_ready_i;
  assign emit      = can_emit && (busy_q || job_valid_i);
  assign job_pop_o = emit && !busy_q;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    rest_d      = rest_q;
    lastv_d     = lastv_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d = 1'b1;
      if (!busy_q && job_i.bad) begin
        out_d = '{out_byte: 8'd0, last_byte: 1'b0,
                  end_of_call: job_i.last_value, bad_kind: 1'b1};
      end else begin
        out_d.out_byte    = ninth ? src[7:0] : {more, src[6:0]};
        out_d.last_byte   = last;
        out_d.end_of_call = last && src_last_value;
        out_d.bad_kind    = 1'b0;
        busy_d            = !last;
        cnt_d             = src_cnt + 1'b1;
        rest_d            = {7'd0, src[63:7]};
        lastv_d           = src_last_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q  <= rest_d;
    lastv_q <= lastv_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `VZE_ASSERT(a_group_bound, busy_q |-> cnt_q <= CntW'(GroupLimit))
  `VZE_ASSERT(a_ninth_is_last, (emit && busy_q && ninth) |=> !busy_q)
  `VZE_ASSERT(a_bad_beat_clean, (out_valid_o && out_o.bad_kind) |-> (!out_o.last_byte && out_o.out_byte == 8'd0))

endmodule

[rtl/varint_zigzag_encoder.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// varint_zigzag_encoder
// Zigzag + base-128 varint encoder, one value in, one to nine bytes out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_i) takes one beat per value: raw
//   bits, a kind (signed/unsigned, 16/32/64 bit) and a last_value mark.
//   Output channel (out_valid_o/out_ready_i/out_o) gives one beat per byte,
//   low group first; last_byte flags the final byte of a value, end_of_call
//   the final byte of a value marked last_value. An invalid kind gives a
//   single beat with bad_kind set and a zero byte.
//   Each input beat is registered in the job queue and each byte in the
//   serializer's output register. The back-end serializer bounds the rate:
//   it emits one byte per cycle while the receiver is ready and starts the
//   next value once the last byte of the previous one is produced.
//   A QueueDepth-entry job queue sits between the classifier and the
//   serializer, so the input keeps accepting while bytes are pending.
//   Reset empties the queue and the output register; no clearing pass.
//   When the receiver stalls, the output beat holds, the serializer waits,
//   and in_ready_o drops once the queue is full.
// ---------------------------------------------------------------------------
module varint_zigzag_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vze_pkg::in_beat_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vze_pkg::out_beat_t out_o
);
  import vze_pkg::*;

  job_t front_job;
  job_t head_job;
  logic q_full, q_valid, q_pop, q_push;

  // Front: kind decode and zigzag mapping, straight into the queue.
  vze_front u_front (
    .beat_i (in_i),
    .job_o  (front_job)
  );

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;

  vze_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (head_job)
  );

  // Back: byte serializer with its own output register.
  vze_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .job_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
